[src/life_grid_generation_engine_core_defines.svh]
// Assertion macros shared by the checker of the life grid engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LGGE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgge: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define LGGE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgge: next-cycle check failed");

`endif

[src/lgge_pkg.sv]
package lgge_pkg;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int REG_IDX_W = 1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_value;
  } in_item_t;

  typedef struct packed {
    logic read_value;
    logic out_of_range;
  } out_item_t;

  // B3/S23: a live cell survives on two or three neighbors, a dead one is born on three.
  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    logic result;
    if (alive) begin
      result = (count == SURVIVE_LOW) || (count == BIRTH_COUNT);
    end else begin
      result = (count == BIRTH_COUNT);
    end
    return result;
  endfunction

endpackage

[src/life_grid_generation_engine_core.sv]
// Game of Life grid engine (rule B3/S23) with one grid row per memory word.
// Input channel (in_valid/in_stall/in_data) takes commands: write one cell, read
// one cell, or compute one generation over the configured rows and columns.
// Every command yields exactly one transfer on the result channel
// (out_valid/out_stall/out_data) carrying read_value and out_of_range.
// The engine works on one command at a time. An in-range read or write passes
// S_CELL (a write reads the row word, then writes it back); out-of-range and
// unused commands go straight to S_EMIT; a generation passes S_ROW_LOAD, then
// S_ROW_CALC one row per cycle through the single read and single write port of
// the grid memory, with the three-row neighbor window held in registers.
// The next command is taken in the cycle after the result is registered, even
// while that result waits on a stalled receiver; the engine then holds before its
// own result until the output register frees up.
// After reset the grid memory is cleared one row per cycle, all MAX_ROWS rows,
// with in_stall high; configuration writes are taken during that pass.
// Row and column counts come from the cfg port and may only change while idle.
module life_grid_generation_engine_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lgge_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lgge_pkg::out_item_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [lgge_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [lgge_pkg::CFG_W-1:0]         cfg_wr_data
);
  import lgge_pkg::*;

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int CIW  = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int PW   = RW + 1;
  localparam int RXW  = (RW > CFG_W) ? RW : CFG_W;
  localparam int CXW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int RCMP = (RW > ROW_W) ? RW : ROW_W;
  localparam int CCMP = (CW > COL_W) ? CW : COL_W;
  localparam int AXW  = (AW > ROW_W) ? AW : ROW_W;
  localparam int IXW  = (CIW > COL_W) ? CIW : COL_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_ROW_LOAD,
    S_ROW_CALC,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    rows_cfg_r;
  logic [CFG_W-1:0]    cols_cfg_r;
  logic [AW-1:0]       clr_ptr_r;
  logic [1:0]          cmd_r;
  logic [AW-1:0]       row_addr_r;
  logic [CIW-1:0]      col_idx_r;
  logic                cell_val_r;
  logic [AW-1:0]       row_ptr_r;
  logic [MAX_COLS-1:0] prev_r;
  logic [MAX_COLS-1:0] cur_r;
  out_item_t           res_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [RXW-1:0]      rows_ext;
  logic [RXW-1:0]      rows_clamp;
  logic [CXW-1:0]      cols_ext;
  logic [CXW-1:0]      cols_clamp;
  logic [RW-1:0]       eff_rows;
  logic [CW-1:0]       eff_cols;
  logic                grid_empty;
  logic                in_oor;
  logic                cell_cmd;
  logic [AXW-1:0]      in_row_ext;
  logic [IXW-1:0]      in_col_ext;
  logic [PW-1:0]       nr_x;
  logic [PW-1:0]       ptr_p1;
  logic [PW-1:0]       ptr_p2;
  logic                have_next;
  logic                read_p2;
  logic [MAX_COLS-1:0] next_row;
  logic [MAX_COLS-1:0] new_row;
  logic [MAX_COLS-1:0] cell_word;
  logic                old_bit;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [MAX_COLS-1:0] ram_rdata;

  // A register value above the grid size acts as the grid size.
  assign rows_ext   = RXW'(rows_cfg_r);
  assign rows_clamp = (rows_ext > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : rows_ext;
  assign eff_rows   = rows_clamp[RW-1:0];
  assign cols_ext   = CXW'(cols_cfg_r);
  assign cols_clamp = (cols_ext > CXW'(MAX_COLS)) ? CXW'(MAX_COLS) : cols_ext;
  assign eff_cols   = cols_clamp[CW-1:0];
  assign grid_empty = (eff_rows == '0) || (eff_cols == '0);

  assign in_oor = (RCMP'(in_data.row) >= RCMP'(eff_rows)) ||
                  (CCMP'(in_data.col) >= CCMP'(eff_cols));
  assign cell_cmd   = (in_data.cmd == CMD_WRITE) || (in_data.cmd == CMD_READ);
  assign in_row_ext = AXW'(in_data.row);
  assign in_col_ext = IXW'(in_data.col);

  assign nr_x      = PW'(eff_rows);
  assign ptr_p1    = PW'(row_ptr_r) + PW'(1);
  assign ptr_p2    = PW'(row_ptr_r) + PW'(2);
  assign have_next = ptr_p1 < nr_x;
  assign read_p2   = ptr_p2 < nr_x;

  // Below the last active row the window sees dead cells.
  assign next_row = have_next ? ram_rdata : '0;

  always_comb begin
    cell_word            = ram_rdata;
    cell_word[col_idx_r] = cell_val_r;
  end
  assign old_bit = ram_rdata[col_idx_r];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Memory port control. During a generation, row r is written while row r+2 is
  // read; row r+1 already sits in the read register, so no row is read after it
  // has been overwritten.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_r;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (cell_cmd && !in_oor) begin
            ram_re    = 1'b1;
            ram_raddr = in_row_ext[AW-1:0];
          end else if ((in_data.cmd == CMD_STEP) && !grid_empty) begin
            ram_re = 1'b1;
          end
        end
      end
      S_CELL: begin
        if (cmd_r == CMD_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = row_addr_r;
          ram_wdata = cell_word;
        end
      end
      S_ROW_LOAD: begin
        if (have_next) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_p1[AW-1:0];
        end
      end
      S_ROW_CALC: begin
        ram_we    = 1'b1;
        ram_waddr = row_ptr_r;
        ram_wdata = new_row;
        if (read_p2) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_p2[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      rows_cfg_r  <= ROWS_RESET;
      cols_cfg_r  <= COLS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_ROWS: rows_cfg_r <= cfg_wr_data;
          REG_COLS: cols_cfg_r <= cfg_wr_data;
          default: begin
          end
        endcase
      end

      // In S_EMIT the output register is reloaded below instead.
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_ptr_r <= clr_ptr_r + AW'(1);
          if (clr_ptr_r == AW'(MAX_ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_data.cmd;
            row_addr_r <= in_row_ext[AW-1:0];
            col_idx_r  <= in_col_ext[CIW-1:0];
            cell_val_r <= in_data.cell_value;
            row_ptr_r  <= '0;
            res_r      <= '{read_value: 1'b0, out_of_range: cell_cmd && in_oor};
            if (cell_cmd) begin
              if (in_oor) begin
                state_r <= S_EMIT;
              end else begin
                state_r <= S_CELL;
              end
            end else if ((in_data.cmd == CMD_STEP) && !grid_empty) begin
              state_r <= S_ROW_LOAD;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_CELL: begin
          if (cmd_r == CMD_READ) begin
            res_r.read_value <= old_bit;
          end
          state_r <= S_EMIT;
        end
        S_ROW_LOAD: begin
          prev_r  <= '0;
          cur_r   <= ram_rdata;
          state_r <= S_ROW_CALC;
        end
        S_ROW_CALC: begin
          prev_r <= cur_r;
          cur_r  <= next_row;
          if (have_next) begin
            row_ptr_r <= row_ptr_r + AW'(1);
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  lgge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  lgge_row_update #(
    .COLS (MAX_COLS)
  ) u_row_update (
    .prev_row    (prev_r),
    .cur_row     (cur_r),
    .next_row    (next_row),
    .cols_active (eff_cols),
    .new_row     (new_row)
  );

endmodule

[src/lgge_ram.sv]
module lgge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/lgge_row_update.sv]
module lgge_row_update #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]             prev_row,
  input  logic [COLS-1:0]             cur_row,
  input  logic [COLS-1:0]             next_row,
  input  logic [$clog2(COLS+1)-1:0]   cols_active,
  output logic [COLS-1:0]             new_row
);
  import lgge_pkg::*;

  localparam int CW = $clog2(COLS + 1);

  logic [COLS-1:0] mask;
  logic [COLS+1:0] pe;
  logic [COLS+1:0] ce;
  logic [COLS+1:0] ne;

  // Columns past the active width count as dead and pad both ends with a dead column.
  assign pe = {1'b0, prev_row & mask, 1'b0};
  assign ce = {1'b0, cur_row & mask, 1'b0};
  assign ne = {1'b0, next_row & mask, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic [3:0] cnt;

    assign mask[c] = CW'(c) < cols_active;
    assign cnt = 4'(pe[c]) + 4'(pe[c+1]) + 4'(pe[c+2]) +
                 4'(ce[c]) + 4'(ce[c+2]) +
                 4'(ne[c]) + 4'(ne[c+1]) + 4'(ne[c+2]);
    // Inactive columns keep their old value.
    assign new_row[c] = mask[c] ? life_rule(ce[c+1], cnt) : cur_row[c];
  end

endmodule

[src/lgge_checker.sv]
`include "life_grid_generation_engine_core_defines.svh"

module lgge_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lgge_pkg::out_item_t out_data
);

  // The grid is cleared right after reset, so no command may be taken then.
  `LGGE_ASSERT_SAME(a_stall_after_reset, !$past(rst_n), in_stall)

  // Commands are handled one at a time: a transfer in closes the input.
  `LGGE_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  // A read result and an out-of-range flag never come together.
  `LGGE_ASSERT_SAME(a_flags_exclusive, out_valid,
                    !(out_data.read_value && out_data.out_of_range))

  // A stalled result stays put.
  `LGGE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind life_grid_generation_engine_core lgge_checker u_lgge_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
